/* hw/rtl/wha_pkg.sv */
// shared types, constants and operation codes of the weighted histogram accumulator
// no dependencies
package wha_pkg;

    localparam int MAX_BINS = 256;
    localparam int SLOTS    = MAX_BINS + 2;
    localparam int ADDR_W   = $clog2(SLOTS);
    localparam int BIN_W    = 10;
    localparam int NUM_W    = 33;
    localparam int CFG_W    = 32;

    localparam logic [1:0] FN_FILL        = 2'd0;
    localparam logic [1:0] FN_SET_CONTENT = 2'd1;
    localparam logic [1:0] FN_SET_ERROR   = 2'd2;
    localparam logic [1:0] FN_READ        = 2'd3;

    localparam logic [1:0] CFG_NUM_BINS  = 2'd0;
    localparam logic [1:0] CFG_LOW_EDGE  = 2'd1;
    localparam logic [1:0] CFG_BIN_WIDTH = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] sample_x;
        logic signed [31:0] weight;
        logic [BIN_W-1:0]   bin_number;
        logic signed [31:0] new_content;
        logic signed [31:0] new_error;
    } t_cmd;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_used;
        logic [31:0]        bin_entries;
        logic signed [47:0] bin_content;
        logic [63:0]        bin_error_sq;
        logic [31:0]        total_entries;
    } t_result;

    typedef struct packed {
        logic [31:0]        entries;
        logic signed [47:0] content;
        logic [63:0]        error_sq;
    } t_bin_rec;

    localparam int REC_W = $bits(t_bin_rec);

endpackage

/* hw/rtl/wha_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module wha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/wha_div.sv */
// restoring divider, one quotient bit per cycle, for the bin index
// depends on wha_pkg
module wha_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wha_pkg::NUM_W-1:0]  i_dividend,
    input  logic [30:0]                i_divisor,
    output logic                       o_done,
    output logic [wha_pkg::NUM_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(wha_pkg::NUM_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [wha_pkg::NUM_W-1:0] r_dvd;
    logic [31:0]               r_rem;

    logic [31:0] trial;
    logic [32:0] diff;

    assign trial = {r_rem[30:0], r_dvd[wha_pkg::NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(wha_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_dvd <= {r_dvd[wha_pkg::NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_dvd <= {r_dvd[wha_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

/* hw/rtl/weighted_histogram_accumulator_core.sv */
// Weighted one-dimensional histogram with underflow and overflow bins.
//
// Command channel: a command in i_cmd is taken at a rising edge with start high
// and busy low. Only one command is in flight at a time; busy stays high until
// its result has been written back.
// Result channel: o_valid is high for exactly one cycle with o_result; the
// receiver cannot stall it and must take it in that cycle.
// Config: i_cfg_we, i_cfg_idx and i_cfg_wdata write num_bins, low_edge or
// bin_width at the edge; write only while busy is low and no result is due.
// Sequence: a fill passes through the one-bit-per-cycle divider for the bin
// index, then the read and write-back of the bin record; set content, set
// error and read skip the divider. A new command may be given in the cycle
// where o_valid is high.
// The bin records live in one ram of MAX_BINS+2 entries, read and written
// back through a single port pair.
// Reset: config returns to its defaults and a clearing pass zeroes all
// MAX_BINS+2 bin records, one a cycle, holding busy high until it is done.
module weighted_histogram_accumulator_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  wha_pkg::t_cmd              i_cmd,
    output logic                       o_valid,
    output wha_pkg::t_result           o_result,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [wha_pkg::CFG_W-1:0]  i_cfg_wdata
);

    localparam int BW = wha_pkg::BIN_W;
    localparam int AW = wha_pkg::ADDR_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [AW-1:0] r_clr_addr;

    logic [8:0]         r_num_bins;
    logic signed [31:0] r_low_edge;
    logic [30:0]        r_bin_width;

    wha_pkg::t_cmd      r_cmd;
    logic [BW-1:0]      r_bin;
    logic               r_low;
    logic               r_rd_ok;
    logic signed [31:0] r_op;
    logic signed [63:0] r_sq;
    logic [31:0]        r_total;
    wha_pkg::t_result   r_res;
    logic               r_valid;

    logic [BW-1:0]      nb, nb_p1, nb_raw;
    logic [30:0]        bw_eff;
    logic signed [33:0] num, bw_s;
    logic               accept;
    logic [BW-1:0]      set_bin;
    logic               div_start, div_done;
    logic [wha_pkg::NUM_W-1:0] quo;
    logic [BW-1:0]      fill_bin;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    wha_pkg::t_bin_rec     ram_wdata, rd_rec, n_rec;
    logic [wha_pkg::REC_W-1:0] ram_rdata;

    logic signed [48:0] cont_sum;
    logic [64:0]        err_sum;
    logic [31:0]        ent_inc, n_total;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // effective bin count and width
    assign nb_raw = {1'b0, r_num_bins};
    always_comb begin
        priority if (nb_raw == '0) begin
            nb = BW'(1);
        end else if (nb_raw > BW'(wha_pkg::MAX_BINS)) begin
            nb = BW'(wha_pkg::MAX_BINS);
        end else begin
            nb = nb_raw;
        end
    end
    assign nb_p1  = nb + 1'b1;
    assign bw_eff = (r_bin_width == '0) ? 31'd1 : r_bin_width;

    assign bw_s = {3'b000, bw_eff};
    assign num  = {{2{i_cmd.sample_x[31]}}, i_cmd.sample_x}
                - {{2{r_low_edge[31]}}, r_low_edge} + bw_s;

    always_comb begin
        priority if (i_cmd.bin_number == '0) begin
            set_bin = '0;
        end else if (i_cmd.bin_number > nb) begin
            set_bin = nb_p1;
        end else begin
            set_bin = i_cmd.bin_number;
        end
    end

    always_comb begin
        priority if (r_low) begin
            fill_bin = '0;
        end else if (quo > wha_pkg::NUM_W'(nb)) begin
            fill_bin = nb_p1;
        end else begin
            fill_bin = quo[BW-1:0];
        end
    end

    assign div_start = accept && (i_cmd.func == wha_pkg::FN_FILL);

    wha_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (num[wha_pkg::NUM_W-1:0]),
        .i_divisor  (bw_eff),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bins  <= 9'd256;
            r_low_edge  <= '0;
            r_bin_width <= 31'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wha_pkg::CFG_NUM_BINS:  r_num_bins  <= i_cfg_wdata[8:0];
                wha_pkg::CFG_LOW_EDGE:  r_low_edge  <= i_cfg_wdata;
                wha_pkg::CFG_BIN_WIDTH: r_bin_width <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(wha_pkg::SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_cmd.func == wha_pkg::FN_FILL) ? S_DIV : S_READ;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_MOD;
            S_MOD:   n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_total    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_MOD);
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_MOD) begin
                r_total <= n_total;
            end
        end
    end

    // command and operand registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_low   <= (num < bw_s);
            r_rd_ok <= (i_cmd.func != wha_pkg::FN_READ) || (i_cmd.bin_number <= nb_p1);
            r_op    <= (i_cmd.func == wha_pkg::FN_FILL) ? i_cmd.weight : i_cmd.new_error;
            r_bin   <= (i_cmd.func == wha_pkg::FN_READ) ? i_cmd.bin_number : set_bin;
        end else if (r_state == S_DIV && div_done) begin
            r_bin <= fill_bin;
        end
        if (r_state == S_READ) begin
            r_sq <= r_op * r_op;
        end
        if (r_state == S_MOD) begin
            r_res.bin_used      <= r_bin;
            r_res.bin_entries   <= r_rd_ok ? n_rec.entries  : '0;
            r_res.bin_content   <= r_rd_ok ? n_rec.content  : '0;
            r_res.bin_error_sq  <= r_rd_ok ? n_rec.error_sq : '0;
            r_res.total_entries <= n_total;
        end
    end

    // read-modify-write of the bin record
    assign rd_rec   = ram_rdata;
    assign ent_inc  = (&rd_rec.entries) ? rd_rec.entries : rd_rec.entries + 1'b1;
    assign cont_sum = {rd_rec.content[47], rd_rec.content}
                    + {{17{r_cmd.weight[31]}}, r_cmd.weight};
    assign err_sum  = {1'b0, rd_rec.error_sq} + {1'b0, r_sq};

    always_comb begin
        n_rec   = rd_rec;
        n_total = r_total;
        unique case (r_cmd.func)
            wha_pkg::FN_FILL: begin
                n_rec.entries = ent_inc;
                if (cont_sum[48] != cont_sum[47]) begin
                    n_rec.content = cont_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                end else begin
                    n_rec.content = cont_sum[47:0];
                end
                n_rec.error_sq = err_sum[64] ? '1 : err_sum[63:0];
                n_total = (&r_total) ? r_total : r_total + 1'b1;
            end
            wha_pkg::FN_SET_CONTENT: begin
                n_rec.entries = ent_inc;
                n_rec.content = {{16{r_cmd.new_content[31]}}, r_cmd.new_content};
                n_total = (&r_total) ? r_total : r_total + 1'b1;
            end
            wha_pkg::FN_SET_ERROR: begin
                n_rec.error_sq = r_sq;
            end
            wha_pkg::FN_READ: ;
            default: ;
        endcase
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == S_MOD) && (r_cmd.func != wha_pkg::FN_READ);
            ram_waddr = r_bin[AW-1:0];
            ram_wdata = n_rec;
        end
    end

    wha_ram #(
        .WIDTH (wha_pkg::REC_W),
        .DEPTH (wha_pkg::SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_bin[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

/* tb/sv/histogram_checker.sv */
// checker for the weighted histogram accumulator: watches the command, result and config ports,
// keeps its own copy of the bin store and compares every result transaction
// depends on wha_pkg
module histogram_checker
    import wha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_cmd              i_cmd,
    input  logic              i_valid,
    input  t_result           i_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output int                o_pending,
    output int                o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CONTENT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint CONTENT_MIN = -CONTENT_MAX - 1;

    logic [8:0]         num_bins_q;
    logic signed [31:0] low_edge_q;
    logic [30:0]        bin_width_q;

    logic [31:0]        entries_q [SLOTS];
    logic signed [47:0] content_q [SLOTS];
    logic [63:0]        square_q  [SLOTS];
    logic [31:0]        total_q;

    t_result expected_results [$];
    int      mismatches = 0;

    function automatic logic [31:0] bump_count(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function automatic int clamp_bin_index(input longint i, input int nb);
        if (i < 1)
            return 0;
        if (i > nb)
            return nb + 1;
        return int'(i);
    endfunction

    function automatic t_result predict_bin_update(input t_cmd c);
        t_result     r;
        int          nb;
        int          b;
        longint      x;
        longint      w;
        longint      lo;
        longint      bw;
        longint      s;
        logic [63:0] sq;
        logic [63:0] e;
        bit          readable;
        nb = (num_bins_q == 0) ? 1 : (num_bins_q > MAX_BINS) ? MAX_BINS : int'(num_bins_q);
        readable = 1'b1;
        b = 0;
        case (c.func)
            FN_FILL: begin
                x  = longint'(c.sample_x);
                w  = longint'(c.weight);
                lo = longint'(low_edge_q);
                bw = (bin_width_q == 0) ? 64'sd1 : longint'(bin_width_q);
                b  = clamp_bin_index((x - lo + bw) / bw, nb);
                entries_q[b] = bump_count(entries_q[b]);
                s = longint'(content_q[b]) + w;
                if (s > CONTENT_MAX)
                    s = CONTENT_MAX;
                if (s < CONTENT_MIN)
                    s = CONTENT_MIN;
                content_q[b] = s[47:0];
                sq = w * w;
                e  = square_q[b] + sq;
                if (e < sq)
                    e = '1;
                square_q[b] = e;
                total_q = bump_count(total_q);
            end
            FN_SET_CONTENT: begin
                b = clamp_bin_index(longint'(c.bin_number), nb);
                entries_q[b] = bump_count(entries_q[b]);
                content_q[b] = 48'(c.new_content);
                total_q = bump_count(total_q);
            end
            FN_SET_ERROR: begin
                x = longint'(c.new_error);
                b = clamp_bin_index(longint'(c.bin_number), nb);
                square_q[b] = x * x;
            end
            FN_READ: begin
                b = int'(c.bin_number);
                readable = (b <= nb + 1);
            end
        endcase
        r.bin_used = b[BIN_W-1:0];
        if (readable) begin
            r.bin_entries  = entries_q[b];
            r.bin_content  = content_q[b];
            r.bin_error_sq = square_q[b];
        end else begin
            r.bin_entries  = '0;
            r.bin_content  = '0;
            r.bin_error_sq = '0;
        end
        r.total_entries = total_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            num_bins_q  = 9'd256;
            low_edge_q  = '0;
            bin_width_q = 31'd65536;
            for (int i = 0; i < SLOTS; i++) begin
                entries_q[i] = '0;
                content_q[i] = '0;
                square_q[i]  = '0;
            end
            total_q = '0;
            expected_results.delete();
        end else begin
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with no command outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.bin_used !== want.bin_used)
                        report_mismatch($sformatf("bin_used %0d, wanted %0d",
                            i_result.bin_used, want.bin_used));
                    if (i_result.bin_entries !== want.bin_entries)
                        report_mismatch($sformatf("bin %0d entries %0d, wanted %0d",
                            want.bin_used, i_result.bin_entries, want.bin_entries));
                    if (i_result.bin_content !== want.bin_content)
                        report_mismatch($sformatf("bin %0d content %h, wanted %h",
                            want.bin_used, i_result.bin_content, want.bin_content));
                    if (i_result.bin_error_sq !== want.bin_error_sq)
                        report_mismatch($sformatf("bin %0d error sum %h, wanted %h",
                            want.bin_used, i_result.bin_error_sq, want.bin_error_sq));
                    if (i_result.total_entries !== want.total_entries)
                        report_mismatch($sformatf("total entries %0d, wanted %0d",
                            i_result.total_entries, want.total_entries));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_BINS:  num_bins_q  = i_cfg_wdata[8:0];
                    CFG_LOW_EDGE:  low_edge_q  = i_cfg_wdata[31:0];
                    CFG_BIN_WIDTH: bin_width_q = i_cfg_wdata[30:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                expected_results.push_back(predict_bin_update(i_cmd));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

/* tb/sv/testbench.sv */
// top of the weighted histogram accumulator testbench: clock, reset, command and config stimulus
// and the verdict; depends on wha_pkg, weighted_histogram_accumulator_core and histogram_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wha_pkg::*;

    localparam int PHASES      = 7;
    localparam int STALL_LIMIT = 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_cmd              i_cmd;
    logic              o_valid;
    t_result           o_result;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_wdata;
    int                pending_results;
    int                mismatch_count;

    logic [8:0]  setting_bins  [PHASES] = '{9'd0, 9'd511, 9'd1, 9'd10, 9'd256, 9'd100, 9'd256};
    logic [31:0] setting_low   [PHASES] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFB_0000,
                                            32'hFFF0_0000, 32'h0, 32'h0123_4567, 32'hFF80_0000};
    logic [30:0] setting_width [PHASES] = '{31'd0, 31'h7FFF_FFFF, 31'h3_0000, 31'h1000,
                                            31'd1, 31'h2_8000, 31'h1_0000};

    int     eff_bins;
    longint low_v;
    longint width_v;
    bit     idle_on;
    bit     last_part;
    bit     random_part;
    int     sent_count;
    int     sent_by_func [4];
    int     stall_cycles;

    weighted_histogram_accumulator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    histogram_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending_results),
        .o_fail_count (mismatch_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_cmd make_cmd(input logic [1:0] func, input logic [31:0] x,
                                      input logic [31:0] w, input logic [BIN_W-1:0] bn,
                                      input logic [31:0] content, input logic [31:0] err);
        t_cmd c;
        c.func        = func;
        c.sample_x    = x;
        c.weight      = w;
        c.bin_number  = bn;
        c.new_content = content;
        c.new_error   = err;
        return c;
    endfunction

    // random commands, half of them fills, with samples mostly aimed at the bins of the current setting
    function automatic t_cmd random_cmd();
        t_cmd   c;
        int     pick;
        int     target;
        longint x;
        pick = $urandom_range(0, 9);
        c.func = (pick < 5) ? FN_FILL : (pick < 7) ? FN_SET_CONTENT :
                 (pick < 8) ? FN_SET_ERROR : FN_READ;
        c.sample_x = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            target = $urandom_range(0, eff_bins + 1);
            x = low_v + (target - 1) * width_v + longint'($urandom) % width_v;
            if (x >= -64'sd2147483648 && x <= 64'sd2147483647)
                c.sample_x = x[31:0];
        end
        case ($urandom_range(0, 3))
            0: c.weight = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1: c.weight = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
            default: c.weight = $urandom;
        endcase
        c.bin_number  = BIN_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, eff_bins + 2)
                                                            : $urandom_range(0, 1023));
        c.new_content = $urandom;
        c.new_error   = $urandom;
        return c;
    endfunction

    // leaves start high after the transaction; the caller lowers it at the end of a phase
    task automatic send(input t_cmd c);
        int gap;
        bit drain;
        if (sent_count % 25 == 0)
            idle_on = !last_part && ($urandom_range(0, 3) != 0);
        gap   = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 18) : 0;
        drain = random_part && !last_part && ($urandom_range(0, 39) == 0);
        if (gap > 0 || drain) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (drain)
                do @(posedge i_clk); while (pending_results != 0 || busy);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        sent_count++;
        sent_by_func[c.func]++;
    endtask

    task automatic apply_setting(input int p);
        do @(posedge i_clk); while (pending_results != 0 || busy);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_NUM_BINS;
        i_cfg_wdata <= 32'(setting_bins[p]);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_LOW_EDGE;
        i_cfg_wdata <= setting_low[p];
        @(posedge i_clk);
        i_cfg_idx   <= CFG_BIN_WIDTH;
        i_cfg_wdata <= {1'($urandom_range(0, 1)), setting_width[p]};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        eff_bins = (setting_bins[p] == 0) ? 1 :
                   (setting_bins[p] > MAX_BINS) ? MAX_BINS : int'(setting_bins[p]);
        low_v    = $signed(setting_low[p]);
        width_v  = (setting_width[p] == 0) ? 64'sd1 : longint'(setting_width[p]);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_NUM_BINS;
        i_cfg_wdata <= '0;
        eff_bins    = MAX_BINS;
        low_v       = 0;
        width_v     = 65536;
        idle_on     = 1'b1;
        last_part   = 1'b0;
        random_part = 1'b0;
        sent_count  = 0;
        sent_by_func = '{0, 0, 0, 0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: 256 bins of width 65536 from zero
        send(make_cmd(FN_READ, 0, 0, 10'd0, 0, 0));
        send(make_cmd(FN_FILL, 32'h0, 32'h0001_0000, '0, 0, 0));
        send(make_cmd(FN_FILL, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '0, 0, 0));
        send(make_cmd(FN_FILL, 32'h8000_0000, 32'h8000_0000, '0, 0, 0));
        send(make_cmd(FN_FILL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0, 0, 0));
        send(make_cmd(FN_FILL, 32'h00FF_8000, 32'h0, '0, 0, 0));
        send(make_cmd(FN_FILL, 32'h0100_0000, 32'h0000_4000, '0, 0, 0));
        send(make_cmd(FN_SET_CONTENT, 0, 0, 10'd5, 32'h7FFF_FFFF, 0));
        send(make_cmd(FN_SET_CONTENT, 0, 0, 10'd0, 32'h8000_0000, 0));
        send(make_cmd(FN_SET_CONTENT, 0, 0, 10'd300, 32'hFFFF_FFFF, 0));
        send(make_cmd(FN_SET_CONTENT, 0, 0, 10'd1023, 32'h1234_5678, 0));
        // error sum of bin 7 driven into saturation
        send(make_cmd(FN_SET_ERROR, 0, 0, 10'd7, 0, 32'h8000_0000));
        repeat (3) send(make_cmd(FN_FILL, 32'h0006_0000, 32'h8000_0000, '0, 0, 0));
        send(make_cmd(FN_SET_ERROR, 0, 0, 10'd1000, 0, 32'h7FFF_FFFF));
        send(make_cmd(FN_SET_ERROR, 0, 0, 10'd0, 0, 32'hFFFF_FFFF));
        send(make_cmd(FN_READ, 0, 0, 10'd7, 0, 0));
        send(make_cmd(FN_READ, 0, 0, 10'd257, 0, 0));
        send(make_cmd(FN_READ, 0, 0, 10'd258, 0, 0));
        send(make_cmd(FN_READ, 0, 0, 10'd1023, 0, 0));
        send(make_cmd(FN_READ, 0, 0, 10'd256, 0, 0));
        send(make_cmd(FN_READ, 0, 0, 10'd5, 0, 0));

        random_part = 1'b1;
        repeat (100) send(random_cmd());
        start <= 1'b0;
        for (int p = 0; p < PHASES; p++) begin
            apply_setting(p);
            last_part = (p == PHASES - 1);
            if (last_part)
                idle_on = 1'b0;
            repeat (last_part ? 150 : 110) send(random_cmd());
            start <= 1'b0;
        end

        do @(posedge i_clk); while (pending_results != 0 || busy);
        repeat (40) @(posedge i_clk);
        $display("%0d commands: %0d fills, %0d content sets, %0d error sets, %0d reads",
                 sent_count, sent_by_func[FN_FILL], sent_by_func[FN_SET_CONTENT],
                 sent_by_func[FN_SET_ERROR], sent_by_func[FN_READ]);
        $display("%0d register settings, incl. zero and oversized bin counts and extreme edges",
                 PHASES + 1);
        if (mismatch_count == 0 && pending_results == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
